### rtl/line_follower_command_executor_unit_assert.svh
// Assertion macros shared by the line follower command executor RTL.
`ifndef LINE_FOLLOWER_COMMAND_EXECUTOR_UNIT_ASSERT_SVH
`define LINE_FOLLOWER_COMMAND_EXECUTOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The expression must never be true while out of reset.
`define LFCE_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("lfce assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define LFCE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lfce assertion failed");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define LFCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lfce assertion failed");

`else

`define LFCE_ASSERT_NEVER(lbl, clk, rst_n, expr)
`define LFCE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define LFCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/lfce_pkg.sv
// Types, constants and codes shared by the line follower command executor.
`default_nettype none

package lfce_pkg;

	localparam int SENSOR_BITS = 10;
	localparam int LETTER_BITS = 8;
	localparam int QUEUE_DEPTH_DEFAULT = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int STOP_BITS = 16;

	localparam logic [SENSOR_BITS-1:0] BLACK_THRESHOLD_RESET = SENSOR_BITS'(512);
	localparam logic [SENSOR_BITS-1:0] NEAR_THRESHOLD_RESET = SENSOR_BITS'(799);
	localparam logic [STOP_BITS-1:0] STOP_DELAY_RESET = STOP_BITS'(5000);
	localparam logic [STOP_BITS-1:0] STOP_TICKS_MAX = '1;

	localparam logic [LETTER_BITS-1:0] LETTER_STOP = 8'h53;
	localparam logic [LETTER_BITS-1:0] LETTER_RIGHT = 8'h52;
	localparam logic [LETTER_BITS-1:0] LETTER_LEFT = 8'h4C;
	localparam logic [LETTER_BITS-1:0] LETTER_SKIP = 8'h31;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BLACK_THRESHOLD = 2'd0,
		REG_NEAR_THRESHOLD = 2'd1,
		REG_STOP_DELAY = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		CMD_OTHER = 3'd0,
		CMD_STOP = 3'd1,
		CMD_RIGHT = 3'd2,
		CMD_LEFT = 3'd3,
		CMD_SKIP = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		SPD_STOP = 3'd0,
		SPD_SLOW = 3'd1,
		SPD_MEDL = 3'd2,
		SPD_MED = 3'd3,
		SPD_MEDH = 3'd4
	} speed_t;

	localparam logic [1:0] TURN_NONE = 2'd0;
	localparam logic [1:0] TURN_RIGHT = 2'd1;
	localparam logic [1:0] TURN_LEFT = 2'd2;

	typedef struct packed {
		logic action;
		logic [LETTER_BITS-1:0] command_letter;
		logic [SENSOR_BITS-1:0] inner_left;
		logic [SENSOR_BITS-1:0] inner_right;
		logic [SENSOR_BITS-1:0] outer_left;
		logic [SENSOR_BITS-1:0] outer_right;
		logic [SENSOR_BITS-1:0] proximity;
	} item_t;

	typedef struct packed {
		logic [2:0] left_speed;
		logic [2:0] right_speed;
		logic [1:0] turn_report;
		logic node_report;
		logic stop_report;
		logic queue_overflow;
		logic driving;
	} result_t;

	// Classified item handed from the front end to the executor.
	typedef struct packed {
		logic is_push;
		cmd_t cmd;
		logic il_hi;
		logic il_lo;
		logic ir_hi;
		logic ir_lo;
		logic ol_hi;
		logic ol_lo;
		logic or_hi;
		logic or_lo;
		logic il_gt_ir;
		logic ir_gt_il;
		logic near;
	} class_t;

endpackage

`default_nettype wire

### rtl/lfce_fifo.sv
// Two-entry queue used between the front end and executor and on the result side.
`default_nettype none

module lfce_fifo #(
	parameter type T = logic
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire T item_in,
	input wire logic pop,
	output logic empty,
	output T item_out
);

	localparam logic [1:0] SLOTS = 2'd2;

	T mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == SLOTS);
	assign empty = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign item_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/lfce_front.sv
// Front end: decodes command letters and compares sensor samples with the thresholds.
`default_nettype none

module lfce_front (
	input wire lfce_pkg::item_t item,
	input wire logic [lfce_pkg::SENSOR_BITS-1:0] black_threshold,
	input wire logic [lfce_pkg::SENSOR_BITS-1:0] near_threshold,
	output lfce_pkg::class_t cls
);

	import lfce_pkg::*;

	cmd_t cmd;

	always_comb begin
		case (item.command_letter)
			LETTER_STOP: cmd = CMD_STOP;
			LETTER_RIGHT: cmd = CMD_RIGHT;
			LETTER_LEFT: cmd = CMD_LEFT;
			LETTER_SKIP: cmd = CMD_SKIP;
			default: cmd = CMD_OTHER;
		endcase
	end

	// A level equal to the threshold is neither above nor below it.
	always_comb begin
		cls.is_push = item.action;
		cls.cmd = cmd;
		cls.il_hi = item.inner_left > black_threshold;
		cls.il_lo = item.inner_left < black_threshold;
		cls.ir_hi = item.inner_right > black_threshold;
		cls.ir_lo = item.inner_right < black_threshold;
		cls.ol_hi = item.outer_left > black_threshold;
		cls.ol_lo = item.outer_left < black_threshold;
		cls.or_hi = item.outer_right > black_threshold;
		cls.or_lo = item.outer_right < black_threshold;
		cls.il_gt_ir = item.inner_left > item.inner_right;
		cls.ir_gt_il = item.inner_right > item.inner_left;
		cls.near = item.proximity < near_threshold;
	end

endmodule

`default_nettype wire

### rtl/lfce_back.sv
// Executor: command queue, route state, speed control and stop timer.
`default_nettype none

module lfce_back #(
	parameter int QUEUE_DEPTH = lfce_pkg::QUEUE_DEPTH_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire lfce_pkg::class_t cls,
	input wire logic [lfce_pkg::STOP_BITS-1:0] stop_delay,
	output lfce_pkg::result_t result
);

	import lfce_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_BITS = CNT_BITS + 1;
	localparam logic [SUM_BITS-1:0] DEPTH_SUM = SUM_BITS'(QUEUE_DEPTH);
	localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(QUEUE_DEPTH);
	localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

	cmd_t cmd_store_q [QUEUE_DEPTH];
	cmd_t head_cmd_q;
	logic [PTR_BITS-1:0] head_q;
	logic [CNT_BITS-1:0] count_q;
	logic task_done_q, want_stop_q, want_left_q, want_right_q, skip_q;
	logic in_turn_q, turn_seen_q, over_node_q;
	logic [STOP_BITS-1:0] stop_ticks_q;
	speed_t left_q, right_q;

	logic [PTR_BITS-1:0] head_d;
	logic [CNT_BITS-1:0] count_d;
	logic task_done_d, want_stop_d, want_left_d, want_right_d, skip_d;
	logic in_turn_d, turn_seen_d, over_node_d;
	logic [STOP_BITS-1:0] stop_ticks_d;
	speed_t left_d, right_d;
	logic [SUM_BITS-1:0] tail_sum;
	logic [PTR_BITS-1:0] tail;
	logic mem_we;
	logic drive;
	logic [1:0] turn_rep;
	logic node_rep, stop_rep, ovf;
	logic [5:0] adj;

	// Straightening against the inner pair; applies only outside a turn.
	function automatic logic [5:0] correct_line(input class_t c, input logic turning,
			input logic armed, input speed_t l, input speed_t r);
		speed_t nl;
		speed_t nr;
		nl = l;
		nr = r;
		if ((c.il_lo || c.ir_lo) && !turning) begin
			if (c.il_gt_ir) begin
				nl = SPD_SLOW;
				nr = SPD_MED;
			end else if (c.ir_gt_il) begin
				nl = SPD_MED;
				nr = SPD_SLOW;
			end
		end
		if (c.il_hi && c.ir_hi && !turning) begin
			if (armed) begin
				nl = SPD_MEDL;
				nr = SPD_MEDL;
			end else begin
				nl = SPD_MED;
				nr = SPD_MED;
			end
		end
		return {nl, nr};
	endfunction

	always_comb begin
		tail_sum = SUM_BITS'(head_q) + SUM_BITS'(count_q);
		if (tail_sum >= DEPTH_SUM) begin
			tail = PTR_BITS'(tail_sum - DEPTH_SUM);
		end else begin
			tail = PTR_BITS'(tail_sum);
		end
	end

	always_comb begin
		head_d = head_q;
		count_d = count_q;
		task_done_d = task_done_q;
		want_stop_d = want_stop_q;
		want_left_d = want_left_q;
		want_right_d = want_right_q;
		skip_d = skip_q;
		in_turn_d = in_turn_q;
		turn_seen_d = turn_seen_q;
		over_node_d = over_node_q;
		stop_ticks_d = stop_ticks_q;
		left_d = left_q;
		right_d = right_q;
		mem_we = 1'b0;
		drive = 1'b0;
		turn_rep = TURN_NONE;
		node_rep = 1'b0;
		stop_rep = 1'b0;
		ovf = 1'b0;
		adj = '0;

		if (cls.is_push) begin
			if (count_q != DEPTH_CNT) begin
				mem_we = fire;
				count_d = count_q + 1'b1;
			end else begin
				ovf = 1'b1;
			end
		end else begin
			if (task_done_q && count_q != '0) begin
				head_d = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
				count_d = count_q - 1'b1;
				task_done_d = 1'b0;
				case (head_cmd_q)
					CMD_STOP: want_stop_d = 1'b1;
					CMD_RIGHT: want_right_d = 1'b1;
					CMD_LEFT: want_left_d = 1'b1;
					CMD_SKIP: skip_d = 1'b1;
					default: ;
				endcase
			end

			drive = !cls.near && !task_done_d && !want_stop_d;

			if (drive) begin
				if (want_left_d) begin
					if (cls.ol_hi) begin
						left_d = SPD_SLOW;
						right_d = SPD_MEDH;
						in_turn_d = 1'b1;
					end
				end else if (want_right_d) begin
					if (cls.or_hi) begin
						left_d = SPD_MEDH;
						right_d = SPD_SLOW;
						in_turn_d = 1'b1;
					end
				end
				adj = correct_line(cls, in_turn_d, want_left_d || want_right_d,
					left_d, right_d);
				left_d = speed_t'(adj[5:3]);
				right_d = speed_t'(adj[2:0]);

				// The inner pair splitting across the tape marks the end of the turn.
				if (in_turn_d && ((cls.ir_lo && cls.il_hi) || (cls.ir_hi && cls.il_lo))) begin
					turn_seen_d = 1'b1;
					in_turn_d = 1'b0;
				end

				if ((want_right_d || want_left_d) && turn_seen_d && cls.il_hi && cls.ir_hi
						&& cls.ol_lo && cls.or_lo) begin
					if (want_right_d) begin
						want_right_d = 1'b0;
						turn_rep = TURN_RIGHT;
					end else begin
						want_left_d = 1'b0;
						turn_rep = TURN_LEFT;
					end
					turn_seen_d = 1'b0;
					task_done_d = 1'b1;
				end

				if (!over_node_d && skip_d && cls.ol_hi && cls.or_hi) begin
					skip_d = 1'b0;
					over_node_d = 1'b1;
				end else if (over_node_d && cls.ol_lo && cls.or_lo) begin
					over_node_d = 1'b0;
					node_rep = 1'b1;
					if (!skip_d) begin
						task_done_d = 1'b1;
					end
				end

				// Second adjustment with the same sample and the updated route state.
				if (in_turn_d) begin
					if (want_left_d) begin
						left_d = SPD_SLOW;
						right_d = SPD_MEDH;
					end else if (want_right_d) begin
						left_d = SPD_MEDH;
						right_d = SPD_SLOW;
					end
				end else begin
					adj = correct_line(cls, in_turn_d,
						want_left_d || want_right_d, left_d, right_d);
					left_d = speed_t'(adj[5:3]);
					right_d = speed_t'(adj[2:0]);
				end
			end else begin
				left_d = SPD_STOP;
				right_d = SPD_STOP;
				if (want_stop_d) begin
					if (stop_ticks_q > stop_delay) begin
						task_done_d = 1'b1;
						want_stop_d = 1'b0;
						want_left_d = 1'b0;
						want_right_d = 1'b0;
						skip_d = 1'b0;
						in_turn_d = 1'b0;
						turn_seen_d = 1'b0;
						over_node_d = 1'b0;
						stop_ticks_d = '0;
						count_d = '0;
						head_d = '0;
						stop_rep = 1'b1;
					end else if (stop_ticks_q != STOP_TICKS_MAX) begin
						stop_ticks_d = stop_ticks_q + 1'b1;
					end
				end
			end
		end

		result.left_speed = left_d;
		result.right_speed = right_d;
		result.turn_report = turn_rep;
		result.node_report = node_rep;
		result.stop_report = stop_rep;
		result.queue_overflow = ovf;
		result.driving = drive;
	end

	// The head entry is read ahead into a register; a write to the new head is forwarded.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cmd_store_q[tail] <= cls.cmd;
		end
		if (fire) begin
			if (mem_we && tail == head_d) begin
				head_cmd_q <= cls.cmd;
			end else begin
				head_cmd_q <= cmd_store_q[head_d];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			task_done_q <= 1'b1;
			want_stop_q <= 1'b0;
			want_left_q <= 1'b0;
			want_right_q <= 1'b0;
			skip_q <= 1'b0;
			in_turn_q <= 1'b0;
			turn_seen_q <= 1'b0;
			over_node_q <= 1'b0;
			stop_ticks_q <= '0;
			left_q <= SPD_STOP;
			right_q <= SPD_STOP;
		end else if (fire) begin
			head_q <= head_d;
			count_q <= count_d;
			task_done_q <= task_done_d;
			want_stop_q <= want_stop_d;
			want_left_q <= want_left_d;
			want_right_q <= want_right_d;
			skip_q <= skip_d;
			in_turn_q <= in_turn_d;
			turn_seen_q <= turn_seen_d;
			over_node_q <= over_node_d;
			stop_ticks_q <= stop_ticks_d;
			left_q <= left_d;
			right_q <= right_d;
		end
	end

endmodule

`default_nettype wire

### rtl/line_follower_command_executor_unit.sv
// Top level of the line follower command executor.
`default_nettype none

// Executes a queue of route letters against one line sensor sample per tick and
// gives one result per input item. Input items are sensor ticks or command
// pushes; the front end classifies each item against the thresholds into a
// two-entry queue, and the executor takes one classified item per cycle into a
// two-entry result queue while that queue has room. Sustained rate is one item
// per clock cycle while items arrive and results are popped; each result is written
// into the result queue when the executor takes its item. Commands are held in a
// store of QUEUE_DEPTH entries whose head is read ahead into a register. Configuration
// writes take effect at once and are meant for times when no item is in flight.
module line_follower_command_executor_unit #(
	parameter int QUEUE_DEPTH = lfce_pkg::QUEUE_DEPTH_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire lfce_pkg::item_t item,
	output logic empty,
	input wire logic pop,
	output lfce_pkg::result_t result,
	input wire logic wr_en,
	input wire logic [lfce_pkg::CFG_INDEX_BITS-1:0] wr_index,
	input wire logic [lfce_pkg::CFG_DATA_BITS-1:0] wr_data
);

	import lfce_pkg::*;

	`include "line_follower_command_executor_unit_assert.svh"

	logic [SENSOR_BITS-1:0] black_threshold_q;
	logic [SENSOR_BITS-1:0] near_threshold_q;
	logic [STOP_BITS-1:0] stop_delay_q;

	class_t cls_in;
	class_t cls_out;
	logic cq_empty;
	logic rq_full;
	logic fire;
	result_t result_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_threshold_q <= BLACK_THRESHOLD_RESET;
			near_threshold_q <= NEAR_THRESHOLD_RESET;
			stop_delay_q <= STOP_DELAY_RESET;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_BLACK_THRESHOLD: black_threshold_q <= wr_data[SENSOR_BITS-1:0];
				REG_NEAR_THRESHOLD: near_threshold_q <= wr_data[SENSOR_BITS-1:0];
				REG_STOP_DELAY: stop_delay_q <= wr_data[STOP_BITS-1:0];
				default: ;
			endcase
		end
	end

	lfce_front u_front (
		.item(item),
		.black_threshold(black_threshold_q),
		.near_threshold(near_threshold_q),
		.cls(cls_in)
	);

	lfce_fifo #(
		.T(class_t)
	) u_class_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item_in(cls_in),
		.pop(fire),
		.empty(cq_empty),
		.item_out(cls_out)
	);

	// The executor runs whenever an item waits and the result queue has room.
	assign fire = !cq_empty && !rq_full;

	lfce_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.cls(cls_out),
		.stop_delay(stop_delay_q),
		.result(result_d)
	);

	lfce_fifo #(
		.T(result_t)
	) u_result_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(fire),
		.full(rq_full),
		.item_in(result_d),
		.pop(pop),
		.empty(empty),
		.item_out(result)
	);

	`LFCE_ASSERT_IMPLIES(a_ovf_on_push, clk, arst_n, fire && result_d.queue_overflow,
		cls_out.is_push)
	`LFCE_ASSERT_IMPLIES(a_stop_still, clk, arst_n, fire && result_d.stop_report,
		!result_d.driving && result_d.left_speed == SPD_STOP && result_d.right_speed == SPD_STOP)
	`LFCE_ASSERT_IMPLIES(a_turn_driving, clk, arst_n, fire && result_d.turn_report != TURN_NONE,
		result_d.driving && !cls_out.is_push)
	`LFCE_ASSERT_NEXT(a_result_lands, clk, arst_n, fire, !empty)

endmodule

`default_nettype wire
